// ===== rtl/scrd_pkg.sv =====
// Shared types, constants and register codes for the stick radial deadzone block.
package scrd_pkg;

    // Defaults for the top-level parameters
    localparam int RAW_BITS_DEF = 12;
    localparam int OUT_FRAC_DEF = 15;

    // Fixed field widths
    localparam int RAW_W      = 12;
    localparam int CAL_W      = 16;
    localparam int ZONE_W     = 16;
    localparam int OUT_W      = 16;
    localparam int QDIV_BITS  = 16;
    localparam int FRAC_W     = QDIV_BITS + 1;
    localparam int SUM_W      = 2 * FRAC_W;
    localparam int MAG_W      = FRAC_W;
    localparam int DEN_W      = MAG_W + QDIV_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << QDIV_BITS;

    // Register reset values
    localparam logic [CAL_W-1:0]  CAL_LOW_RST = 16'd0;
    localparam logic [CAL_W-1:0]  CAL_MID_RST = 16'd2048;
    localparam logic [CAL_W-1:0]  CAL_TOP_RST = 16'd4095;
    localparam logic [ZONE_W-1:0] INNER_RST   = 16'd9830;
    localparam logic [ZONE_W-1:0] OUTER_RST   = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LOW = 3'd0,
        REG_X_MID = 3'd1,
        REG_X_TOP = 3'd2,
        REG_Y_LOW = 3'd3,
        REG_Y_MID = 3'd4,
        REG_Y_TOP = 3'd5,
        REG_INNER = 3'd6,
        REG_OUTER = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic                    in_deadzone;
    } result_t;

    // Calibration as seen by both halves
    typedef struct packed {
        logic [CAL_W-1:0]  x_low;
        logic [CAL_W-1:0]  x_mid;
        logic [CAL_W-1:0]  x_top;
        logic [CAL_W-1:0]  y_low;
        logic [CAL_W-1:0]  y_mid;
        logic [CAL_W-1:0]  y_top;
        logic [ZONE_W-1:0] inner_zone;
        logic [ZONE_W-1:0] outer_zone;
    } cal_t;

    // Normalized vector handed from front to back
    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic              nx;
        logic [FRAC_W-1:0] fy;
        logic              ny;
        logic [MAG_W-1:0]  mag;
    } vec_t;

endpackage

// ===== rtl/stick_calibrate_radial_deadzone.sv =====
// Top level: calibration registers, front and back halves, queues between and after.
//
//   channel   direction  handshake          beat
//   sample    in         push / full        raw_x, raw_y
//   result    out        pop / empty        out_x, out_y, in_deadzone
//   cfg       in         cfg_valid / ready  cfg_index, cfg_data
//
// One sample enters per cycle while full is low; a result passes 35 front stages
// (16-bit divider, 17-bit root), a middle queue beat, OUT_FRAC_BITS + 19 back
// stages (band and scaling dividers) and a result queue beat on its way from
// the sample ports to the result ports.
// Reset loads the calibration defaults and empties every stage and queue.
// A full result queue stalls only the back half; the front keeps filling the
// middle queue until it is full, and full is raised only then.
module stick_calibrate_radial_deadzone
    import scrd_pkg::*;
#(
    parameter int RAW_BITS      = RAW_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sample_t               sample,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cal_t    cal_reg;
    logic    front_ready;
    logic    front_valid;
    vec_t    front_data;
    logic    mid_push, mid_full, mid_empty, mid_pop;
    vec_t    mid_data;
    logic    back_ready;
    logic    back_valid;
    result_t back_data;
    logic    res_full;
    logic [CAL_W-1:0] cal_val;

    assign cfg_ready = 1'b1;
    assign cal_val   = CAL_W'(cfg_data[RAW_BITS-1:0]);

    // Hold calibration; write one register per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.x_low      <= CAL_LOW_RST;
            cal_reg.x_mid      <= CAL_MID_RST;
            cal_reg.x_top      <= CAL_TOP_RST;
            cal_reg.y_low      <= CAL_LOW_RST;
            cal_reg.y_mid      <= CAL_MID_RST;
            cal_reg.y_top      <= CAL_TOP_RST;
            cal_reg.inner_zone <= INNER_RST;
            cal_reg.outer_zone <= OUTER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_X_LOW: cal_reg.x_low      <= cal_val;
                REG_X_MID: cal_reg.x_mid      <= cal_val;
                REG_X_TOP: cal_reg.x_top      <= cal_val;
                REG_Y_LOW: cal_reg.y_low      <= cal_val;
                REG_Y_MID: cal_reg.y_mid      <= cal_val;
                REG_Y_TOP: cal_reg.y_top      <= cal_val;
                REG_INNER: cal_reg.inner_zone <= ZONE_W'(cfg_data);
                REG_OUTER: cal_reg.outer_zone <= ZONE_W'(cfg_data);
            endcase
        end
    end

    assign full = !front_ready;

    scrd_front #(
        .RAW_BITS (RAW_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_data   (sample),
        .in_ready  (front_ready),
        .cal       (cal_reg),
        .out_valid (front_valid),
        .out_data  (front_data),
        .out_full  (mid_full)
    );

    // Decouple the halves
    assign mid_push = front_valid && !mid_full;
    assign mid_pop  = !mid_empty && back_ready;

    scrd_fifo #(
        .WIDTH ($bits(vec_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (front_data),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_data),
        .empty (mid_empty)
    );

    scrd_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_data   (mid_data),
        .in_ready  (back_ready),
        .cal       (cal_reg),
        .out_valid (back_valid),
        .out_data  (back_data),
        .out_full  (res_full)
    );

    // Result queue
    scrd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .din   (back_data),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.in_deadzone) |-> (result.out_x == '0 && result.out_y == '0))
        else $error("deadzone result with nonzero position");

    a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (mid_full && front_valid))
        else $error("input stalled while middle queue had room");

    a_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("middle queue popped while empty");
`endif

endmodule

// ===== rtl/scrd_fifo.sv =====
// Small register queue with count-based full and empty flags.
module scrd_fifo
    import scrd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/scrd_front.sv =====
// Front half: clamp, per-axis normalize by pipelined division, radial magnitude.
module scrd_front
    import scrd_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  sample_t in_data,
    output logic    in_ready,
    input  cal_t    cal,
    output logic    out_valid,
    output vec_t    out_data,
    input  logic    out_full
);

    localparam int NDIV    = QDIV_BITS;
    localparam int NSQ     = MAG_W;
    localparam int ST_SQ   = NDIV + 1;
    localparam int ST_LAST = ST_SQ + NSQ;
    localparam int NF      = ST_LAST + 1;

    logic [NF-1:0] v_reg;
    logic          en;

    logic [RAW_BITS-1:0] raw_v [2];
    logic [RAW_BITS-1:0] lo_v  [2];
    logic [RAW_BITS-1:0] mid_v [2];
    logic [RAW_BITS-1:0] hi_v  [2];

    logic [RAW_BITS-1:0] clamp_c [2];
    logic [RAW_BITS-1:0] d_c     [2];
    logic [RAW_BITS-1:0] span_c  [2];
    logic                zero_c  [2];
    logic                sat_c   [2];
    logic                neg_c   [2];

    // Divider pipeline, index 0 is the prep stage
    logic [RAW_BITS-1:0]  rem_reg  [2][NDIV+1];
    logic [RAW_BITS-1:0]  span_reg [2][NDIV+1];
    logic [QDIV_BITS-1:0] q_reg    [2][NDIV+1];
    logic                 zero_reg [2][NDIV+1];
    logic                 sat_reg  [2][NDIV+1];
    logic                 neg_reg  [2][NDIV+1];
    logic [RAW_BITS:0]    dsh_c    [2][NDIV+1];
    logic                 dbit_c   [2][NDIV+1];
    logic [RAW_BITS-1:0]  rem_next [2][NDIV+1];

    logic [FRAC_W-1:0] f_c  [2];
    logic              ng_c [2];
    logic [SUM_W-1:0]  sq_c [2];
    logic [SUM_W-1:0]  sum_c;

    // Square-root pipeline, index 0 is the sum-of-squares stage
    logic [FRAC_W-1:0] f_reg     [2][NSQ+1];
    logic              ng_reg    [2][NSQ+1];
    logic [SUM_W-1:0]  rad_reg   [NSQ+1];
    logic [MAG_W-1:0]  root_reg  [NSQ+1];
    logic [SUM_W:0]    trial_c   [NSQ+1];
    logic              take_c    [NSQ+1];
    logic [SUM_W-1:0]  rad_next  [NSQ+1];
    logic [MAG_W-1:0]  root_next [NSQ+1];

    assign en       = !v_reg[ST_LAST] || !out_full;
    assign in_ready = en;

    assign raw_v[0] = RAW_BITS'(in_data.raw_x);
    assign raw_v[1] = RAW_BITS'(in_data.raw_y);
    assign lo_v[0]  = cal.x_low[RAW_BITS-1:0];
    assign lo_v[1]  = cal.y_low[RAW_BITS-1:0];
    assign mid_v[0] = cal.x_mid[RAW_BITS-1:0];
    assign mid_v[1] = cal.y_mid[RAW_BITS-1:0];
    assign hi_v[0]  = cal.x_top[RAW_BITS-1:0];
    assign hi_v[1]  = cal.y_top[RAW_BITS-1:0];

    // Clamp, low bound first, then pick the side of center
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (raw_v[a] < lo_v[a])
            begin
                clamp_c[a] = lo_v[a];
            end
            else if (raw_v[a] > hi_v[a])
            begin
                clamp_c[a] = hi_v[a];
            end
            else
            begin
                clamp_c[a] = raw_v[a];
            end
            if (clamp_c[a] >= mid_v[a])
            begin
                neg_c[a]  = 1'b0;
                zero_c[a] = (hi_v[a] <= mid_v[a]);
                d_c[a]    = clamp_c[a] - mid_v[a];
                span_c[a] = hi_v[a] - mid_v[a];
            end
            else
            begin
                neg_c[a]  = 1'b1;
                zero_c[a] = (lo_v[a] >= mid_v[a]);
                d_c[a]    = mid_v[a] - clamp_c[a];
                span_c[a] = mid_v[a] - lo_v[a];
            end
            // distance at or past the span saturates to one
            sat_c[a] = !zero_c[a] && (d_c[a] >= span_c[a]);
        end
    end

    // One restoring quotient bit per stage
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            dsh_c[a][0]    = '0;
            dbit_c[a][0]   = 1'b0;
            rem_next[a][0] = '0;
            for (int k = 1; k <= NDIV; k++)
            begin
                dsh_c[a][k]  = {rem_reg[a][k-1], 1'b0};
                dbit_c[a][k] = (dsh_c[a][k] >= {1'b0, span_reg[a][k-1]});
                rem_next[a][k] = dbit_c[a][k]
                    ? RAW_BITS'(dsh_c[a][k] - {1'b0, span_reg[a][k-1]})
                    : RAW_BITS'(dsh_c[a][k]);
            end
        end
    end

    // Form the Q1.16 fraction and square it
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (zero_reg[a][NDIV])
            begin
                f_c[a] = '0;
            end
            else if (sat_reg[a][NDIV])
            begin
                f_c[a] = FRAC_ONE;
            end
            else
            begin
                f_c[a] = {1'b0, q_reg[a][NDIV]};
            end
            ng_c[a] = neg_reg[a][NDIV] && (f_c[a] != '0);
            sq_c[a] = f_c[a] * f_c[a];
        end
        sum_c = sq_c[0] + sq_c[1];
    end

    // One root bit per stage, remainder form
    always_comb
    begin
        trial_c[0]   = '0;
        take_c[0]    = 1'b0;
        rad_next[0]  = '0;
        root_next[0] = '0;
        for (int j = 1; j <= NSQ; j++)
        begin
            trial_c[j] = ((SUM_W+1)'(root_reg[j-1]) << (NSQ - j + 1))
                       + ((SUM_W+1)'(1) << (2 * (NSQ - j)));
            take_c[j]  = (trial_c[j] <= {1'b0, rad_reg[j-1]});
            rad_next[j] = take_c[j] ? SUM_W'({1'b0, rad_reg[j-1]} - trial_c[j])
                                    : rad_reg[j-1];
            root_next[j] = take_c[j] ? (root_reg[j-1] | (MAG_W'(1) << (NSQ - j)))
                                     : root_reg[j-1];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NF-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                rem_reg[a][0]  <= d_c[a];
                span_reg[a][0] <= span_c[a];
                q_reg[a][0]    <= '0;
                zero_reg[a][0] <= zero_c[a];
                sat_reg[a][0]  <= sat_c[a];
                neg_reg[a][0]  <= neg_c[a];
                for (int k = 1; k <= NDIV; k++)
                begin
                    rem_reg[a][k]  <= rem_next[a][k];
                    span_reg[a][k] <= span_reg[a][k-1];
                    q_reg[a][k]    <= {q_reg[a][k-1][QDIV_BITS-2:0], dbit_c[a][k]};
                    zero_reg[a][k] <= zero_reg[a][k-1];
                    sat_reg[a][k]  <= sat_reg[a][k-1];
                    neg_reg[a][k]  <= neg_reg[a][k-1];
                end
                f_reg[a][0]  <= f_c[a];
                ng_reg[a][0] <= ng_c[a];
                for (int j = 1; j <= NSQ; j++)
                begin
                    f_reg[a][j]  <= f_reg[a][j-1];
                    ng_reg[a][j] <= ng_reg[a][j-1];
                end
            end
            rad_reg[0]  <= sum_c;
            root_reg[0] <= '0;
            for (int j = 1; j <= NSQ; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    assign out_valid   = v_reg[ST_LAST];
    assign out_data.fx  = f_reg[0][NSQ];
    assign out_data.nx  = ng_reg[0][NSQ];
    assign out_data.fy  = f_reg[1][NSQ];
    assign out_data.ny  = ng_reg[1][NSQ];
    assign out_data.mag = root_reg[NSQ];

endmodule

// ===== rtl/scrd_back.sv =====
// Back half: deadzone test, band rescale division, per-axis scaling division.
module scrd_back
    import scrd_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  vec_t    in_data,
    output logic    in_ready,
    input  cal_t    cal,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_full
);

    localparam int NDIV    = QDIV_BITS;
    localparam int NQ      = OUT_FRAC_BITS + 1;
    localparam int ST_MUL  = NDIV + 1;
    localparam int ST_LAST = ST_MUL + NQ;
    localparam int NB      = ST_LAST + 1;
    localparam int QE      = NQ + OUT_W;

    localparam logic [NQ-1:0] Q_LIM = NQ'(1) << OUT_FRAC_BITS;

    logic [NB-1:0] v_reg;
    logic          en;

    logic [FRAC_W-1:0] used_c, legal_c, num_c;
    logic              dz_c, sat_c;

    // Band divider, index 0 is the prep stage
    logic [FRAC_W-1:0]    rem_reg   [NDIV+1];
    logic [FRAC_W-1:0]    legal_reg [NDIV+1];
    logic [QDIV_BITS-1:0] q_reg     [NDIV+1];
    logic                 sat_reg   [NDIV+1];
    logic                 dz_reg    [NDIV+1];
    logic [MAG_W-1:0]     mag_reg   [NDIV+1];
    logic [FRAC_W-1:0]    f_reg     [2][NDIV+1];
    logic                 ng_reg    [2][NDIV+1];
    logic [FRAC_W:0]      dsh_c     [NDIV+1];
    logic                 dbit_c    [NDIV+1];
    logic [FRAC_W-1:0]    rem_next  [NDIV+1];

    logic [FRAC_W-1:0] nm_c;
    logic [SUM_W-1:0]  prd_c [2];

    // Scaling divider, index 0 is the multiply stage
    logic [SUM_W-1:0] prd_reg  [2][NQ+1];
    logic [NQ-1:0]    qo_reg   [2][NQ+1];
    logic             ng2_reg  [2][NQ+1];
    logic [DEN_W-1:0] den_reg  [NQ+1];
    logic             dz2_reg  [NQ+1];
    logic             qbit_c   [2][NQ+1];
    logic [SUM_W-1:0] pdif_c   [2][NQ+1];
    logic [SUM_W-1:0] prd_next [2][NQ+1];

    logic [NQ-1:0]          qc_c  [2];
    logic [QE-1:0]          ext_c [2];
    logic [QE-1:0]          val_c [2];

    assign en       = !v_reg[ST_LAST] || !out_full;
    assign in_ready = en;

    // Deadzone test and band setup
    always_comb
    begin
        dz_c    = (in_data.mag <= {1'b0, cal.inner_zone});
        used_c  = {1'b0, cal.inner_zone} + {1'b0, cal.outer_zone};
        legal_c = FRAC_ONE - used_c;
        num_c   = in_data.mag - {1'b0, cal.inner_zone};
        // an empty band or a magnitude past it gives full scale
        sat_c   = used_c[FRAC_W-1] || (num_c >= legal_c);
    end

    // One restoring quotient bit per stage
    always_comb
    begin
        dsh_c[0]    = '0;
        dbit_c[0]   = 1'b0;
        rem_next[0] = '0;
        for (int k = 1; k <= NDIV; k++)
        begin
            dsh_c[k]    = {rem_reg[k-1], 1'b0};
            dbit_c[k]   = (dsh_c[k] >= {1'b0, legal_reg[k-1]});
            rem_next[k] = dbit_c[k] ? FRAC_W'(dsh_c[k] - {1'b0, legal_reg[k-1]})
                                    : FRAC_W'(dsh_c[k]);
        end
    end

    // Rescaled magnitude times each axis fraction
    always_comb
    begin
        nm_c = sat_reg[NDIV] ? FRAC_ONE : {1'b0, q_reg[NDIV]};
        for (int a = 0; a < 2; a++)
        begin
            prd_c[a] = f_reg[a][NDIV] * nm_c;
        end
    end

    // Divide by magnitude, one quotient bit per stage
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            qbit_c[a][0]   = 1'b0;
            pdif_c[a][0]   = '0;
            prd_next[a][0] = '0;
            for (int j = 1; j <= NQ; j++)
            begin
                qbit_c[a][j] = (prd_reg[a][j-1] >= SUM_W'(den_reg[j-1]));
                pdif_c[a][j] = qbit_c[a][j] ? (prd_reg[a][j-1] - SUM_W'(den_reg[j-1]))
                                            : prd_reg[a][j-1];
                prd_next[a][j] = {pdif_c[a][j][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NB-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num_c;
            legal_reg[0] <= legal_c;
            q_reg[0]     <= '0;
            sat_reg[0]   <= sat_c;
            dz_reg[0]    <= dz_c;
            mag_reg[0]   <= in_data.mag;
            f_reg[0][0]  <= in_data.fx;
            f_reg[1][0]  <= in_data.fy;
            ng_reg[0][0] <= in_data.nx;
            ng_reg[1][0] <= in_data.ny;
            for (int k = 1; k <= NDIV; k++)
            begin
                rem_reg[k]   <= rem_next[k];
                legal_reg[k] <= legal_reg[k-1];
                q_reg[k]     <= {q_reg[k-1][QDIV_BITS-2:0], dbit_c[k]};
                sat_reg[k]   <= sat_reg[k-1];
                dz_reg[k]    <= dz_reg[k-1];
                mag_reg[k]   <= mag_reg[k-1];
                for (int a = 0; a < 2; a++)
                begin
                    f_reg[a][k]  <= f_reg[a][k-1];
                    ng_reg[a][k] <= ng_reg[a][k-1];
                end
            end
            den_reg[0] <= {mag_reg[NDIV], {QDIV_BITS{1'b0}}};
            dz2_reg[0] <= dz_reg[NDIV];
            for (int a = 0; a < 2; a++)
            begin
                prd_reg[a][0] <= prd_c[a];
                qo_reg[a][0]  <= '0;
                ng2_reg[a][0] <= ng_reg[a][NDIV];
            end
            for (int j = 1; j <= NQ; j++)
            begin
                den_reg[j] <= den_reg[j-1];
                dz2_reg[j] <= dz2_reg[j-1];
                for (int a = 0; a < 2; a++)
                begin
                    prd_reg[a][j] <= prd_next[a][j];
                    qo_reg[a][j]  <= {qo_reg[a][j-1][NQ-2:0], qbit_c[a][j]};
                    ng2_reg[a][j] <= ng2_reg[a][j-1];
                end
            end
        end
    end

    // Saturate, apply sign, truncate to the output word; zero both axes in the deadzone
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (ng2_reg[a][NQ])
            begin
                qc_c[a] = (qo_reg[a][NQ] > Q_LIM) ? Q_LIM : qo_reg[a][NQ];
            end
            else
            begin
                qc_c[a] = (qo_reg[a][NQ] > Q_LIM - 1'b1) ? Q_LIM - 1'b1 : qo_reg[a][NQ];
            end
            ext_c[a] = QE'(qc_c[a]);
            val_c[a] = ng2_reg[a][NQ] ? (QE'(0) - ext_c[a]) : ext_c[a];
        end
        if (dz2_reg[NQ])
        begin
            out_data.out_x       = '0;
            out_data.out_y       = '0;
            out_data.in_deadzone = 1'b1;
        end
        else
        begin
            out_data.out_x       = signed'(val_c[0][OUT_W-1:0]);
            out_data.out_y       = signed'(val_c[1][OUT_W-1:0]);
            out_data.in_deadzone = 1'b0;
        end
    end

    assign out_valid = v_reg[ST_LAST];

endmodule
